// ===== rtl/sdt_pkg.sv =====
// ----------------------------------------------------------------------------
// sdt_pkg: shared types and constants of the sorted distance table
// Field widths, request and status codes, the fixed-point scale and the
// command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdt_pkg;

  // Payload field widths.
  localparam int REQ_W   = 3;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 6;
  localparam int UC_W    = 7;

  // Fixed-point scale: unsigned Q12.20.
  localparam int FRACTION_BITS = 20;

  // One unit in the listing compare; the listing starts from minus one.
  localparam logic [VALUE_W+1:0] ONE_FX = (VALUE_W + 2)'(1) << FRACTION_BITS;

  // Resolution after reset: 1e-5 in the fixed-point scale, rounded down.
  localparam logic [63:0]        ONE_WIDE  = 64'd1 << FRACTION_BITS;
  localparam logic [VALUE_W-1:0] RES_RESET = VALUE_W'(ONE_WIDE / 64'd100000);

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_FIND   = 3'd1,
    REQ_COUNT  = 3'd2,
    REQ_LIST   = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_EV,
    ST_INS_PUT,
    ST_FND_RD,
    ST_FND_EV,
    ST_CNT_START,
    ST_CNT_RD,
    ST_CNT_EV,
    ST_EMIT,
    ST_LST_START,
    ST_LST_RD,
    ST_LST_EV,
    ST_LST_FIN
  } state_e;

  // Index counter operations.
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_OCC,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  // Result register loads.
  typedef enum logic [2:0] {
    RES_HOLD,
    RES_ZERO,
    RES_EMPTY,
    RES_FULL,
    RES_INS,
    RES_FIND
  } res_op_e;

  // Output register loads.
  typedef enum logic [2:0] {
    OUT_NONE,
    OUT_RES,
    OUT_PEND_MID,
    OUT_PEND_LAST,
    OUT_MARK
  } out_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_d;
    idx_op_e idx_op;
    logic    rd_prev;
    logic    mem_we;
    logic    wr_d;
    logic    occ_clr;
    logic    occ_inc;
    res_op_e res_op;
    logic    prev_load;
    logic    cnt_clr;
    logic    cnt_step;
    logic    lst_clr;
    logic    lst_take;
    out_op_e out_op;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic occ_zero;
    logic occ_full;
    logic idx_last;
    logic idx_one;
    logic ge;
    logic listed;
    logic k_last;
    logic pend_valid;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/sdt_ifs.sv =====
// ----------------------------------------------------------------------------
// sdt_ifs: channel interfaces of the sorted distance table
// Request, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Request channel: request type and distance operand.
interface sdt_req_if import sdt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [VALUE_W-1:0] distance;

  modport source (output valid, output req_type, output distance, input ready);
  modport sink   (input valid, input req_type, input distance, output ready);
endinterface

// Result channel: one transaction per result item.
interface sdt_rsp_if import sdt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [VALUE_W-1:0] value;
  logic [POS_W-1:0]   position;
  logic [UC_W-1:0]    unique_count;
  logic               last;

  modport source (output valid, output status, output value, output position,
                  output unique_count, output last, input ready);
  modport sink   (input valid, input status, input value, input position,
                  input unique_count, input last, output ready);
endinterface

// Configuration channel: write data of the resolution register.
interface sdt_cfg_if import sdt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sdt_dp.sv =====
// ----------------------------------------------------------------------------
// sdt_dp: datapath of the sorted distance table
// Table memory, occupancy, index and count registers, the resolution
// register, the compare logic and the result output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdt_dp import sdt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [VALUE_W-1:0] distance_i,
  input  logic               cfg_valid_i,
  input  logic [VALUE_W-1:0] cfg_data_i,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  logic               rsp_ready_i,
  output logic               rsp_valid_o,
  output logic [STAT_W-1:0]  status_o,
  output logic [VALUE_W-1:0] value_o,
  output logic [POS_W-1:0]   position_o,
  output logic [UC_W-1:0]    unique_count_o,
  output logic               last_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned IW = AW + 1;

  // Table storage and its registered read data.
  logic [VALUE_W-1:0] mem_q [TABLE_DEPTH];
  logic [VALUE_W-1:0] rdata_q;

  // Control and payload registers.
  logic [VALUE_W-1:0] res_q;
  logic [VALUE_W-1:0] d_q;
  logic [VALUE_W-1:0] prev_q;
  logic [IW-1:0]      occ_q;
  logic [IW-1:0]      idx_q;
  logic [IW-1:0]      cnt_q;
  logic [IW-1:0]      k_q;
  logic [AW-1:0]      pend_pos_q;
  logic               pend_valid_q;
  stat_e              res_status_q;
  logic [VALUE_W-1:0] res_value_q;
  logic [AW-1:0]      res_pos_q;
  logic               out_valid_q;
  stat_e              out_status_q;
  logic [VALUE_W-1:0] out_value_q;
  logic [POS_W-1:0]   out_pos_q;
  logic [UC_W-1:0]    out_uc_q;
  logic               out_last_q;

  // Combinational helpers.
  logic [IW-1:0]      idx_m1;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic [VALUE_W-1:0] gap;
  logic               gap_big;
  logic               first_big;
  logic               ge;
  logic               take_prev;
  logic               out_free;

  // Addresses: the insert sweep reads one below the slot that it writes.
  assign idx_m1  = idx_q - IW'(1);
  assign rd_addr = cmd_i.rd_prev ? idx_m1[AW-1:0] : idx_q[AW-1:0];
  assign wr_addr = idx_q[AW-1:0];
  assign wr_data = cmd_i.wr_d ? d_q : rdata_q;

  // Compares on the entry just read.
  assign ge        = (rdata_q >= d_q);
  assign gap       = rdata_q - prev_q;
  assign gap_big   = (gap > res_q);
  assign first_big = (({2'b00, rdata_q} + ONE_FX) > {2'b00, res_q});
  assign take_prev = ge && (idx_q != '0) && ((d_q - prev_q) < (rdata_q - d_q));
  assign out_free  = !out_valid_q || rsp_ready_i;

  // Status back to the controller.
  always_comb begin
    sts_o.occ_zero   = (occ_q == '0);
    sts_o.occ_full   = (occ_q == IW'(TABLE_DEPTH));
    sts_o.idx_last   = ((idx_q + IW'(1)) == occ_q);
    sts_o.idx_one    = (idx_q == IW'(1));
    sts_o.ge         = ge;
    sts_o.listed     = pend_valid_q ? gap_big : first_big;
    sts_o.k_last     = ((k_q + IW'(1)) == cnt_q);
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = out_free;
  end

  // Table memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Resolution register, occupancy and sweep counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q        <= RES_RESET;
      occ_q        <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
      k_q          <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        res_q <= cfg_data_i;
      end
      if (cmd_i.occ_clr) begin
        occ_q <= '0;
      end else if (cmd_i.occ_inc) begin
        occ_q <= occ_q + IW'(1);
      end
      unique case (cmd_i.idx_op)
        IDX_HOLD: idx_q <= idx_q;
        IDX_ZERO: idx_q <= '0;
        IDX_OCC:  idx_q <= occ_q;
        IDX_INC:  idx_q <= idx_q + IW'(1);
        IDX_DEC:  idx_q <= idx_m1;
        default:  idx_q <= idx_q;
      endcase
      // The first entry counts one, each wide gap one more.
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_step) begin
        if (idx_q == '0) begin
          cnt_q <= IW'(1);
        end else if (gap_big) begin
          cnt_q <= cnt_q + IW'(1);
        end
      end
      if (cmd_i.lst_clr) begin
        k_q          <= '0;
        pend_valid_q <= 1'b0;
      end else if (cmd_i.lst_take) begin
        k_q          <= k_q + IW'(1);
        pend_valid_q <= 1'b1;
      end
    end
  end

  // Operand, previous entry and pending listed entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_d) begin
      d_q <= distance_i;
    end
    if (cmd_i.prev_load || cmd_i.lst_take) begin
      prev_q <= rdata_q;
    end
    if (cmd_i.lst_take) begin
      pend_pos_q <= idx_q[AW-1:0];
    end
  end

  // Result of the current request, held until it is sent.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.res_op)
      RES_HOLD: begin
      end
      RES_ZERO: begin
        res_status_q <= STAT_OK;
        res_value_q  <= '0;
        res_pos_q    <= '0;
      end
      RES_EMPTY: begin
        res_status_q <= STAT_EMPTY;
        res_value_q  <= '0;
        res_pos_q    <= '0;
      end
      // Issued in the accepting cycle, so the operand comes from the port.
      RES_FULL: begin
        res_status_q <= STAT_FULL;
        res_value_q  <= distance_i;
        res_pos_q    <= '0;
      end
      RES_INS: begin
        res_status_q <= STAT_OK;
        res_value_q  <= d_q;
        res_pos_q    <= idx_q[AW-1:0];
      end
      // On a tie the later entry wins, so the earlier one needs a strict win.
      RES_FIND: begin
        res_status_q <= STAT_OK;
        res_value_q  <= take_prev ? prev_q : rdata_q;
        res_pos_q    <= take_prev ? idx_m1[AW-1:0] : idx_q[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Output register: valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_op != OUT_NONE) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.out_op)
      OUT_NONE: begin
      end
      OUT_RES: begin
        out_status_q <= res_status_q;
        out_value_q  <= res_value_q;
        out_pos_q    <= POS_W'(res_pos_q);
        out_uc_q     <= UC_W'(cnt_q);
        out_last_q   <= 1'b1;
      end
      OUT_PEND_MID, OUT_PEND_LAST: begin
        out_status_q <= STAT_OK;
        out_value_q  <= prev_q;
        out_pos_q    <= POS_W'(pend_pos_q);
        out_uc_q     <= UC_W'(cnt_q);
        out_last_q   <= (cmd_i.out_op == OUT_PEND_LAST);
      end
      // Nothing listed: one closing marker.
      OUT_MARK: begin
        out_status_q <= stat_e'((occ_q == '0) ? STAT_EMPTY : STAT_OK);
        out_value_q  <= '0;
        out_pos_q    <= '0;
        out_uc_q     <= UC_W'(cnt_q);
        out_last_q   <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign rsp_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign value_o        = out_value_q;
  assign position_o     = out_pos_q;
  assign unique_count_o = out_uc_q;
  assign last_o         = out_last_q;

endmodule

// ===== rtl/sdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdt_ctrl: controller of the sorted distance table
// State machine that sequences the insert, search, count and listing sweeps
// over the table and issues datapath commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdt_ctrl import sdt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic [REQ_W-1:0] req_type_i,
  output logic             req_ready_o,
  input  dp_sts_t          sts_i,
  output dp_cmd_t          cmd_o
);

  state_e st_q, st_d;
  logic   list_q, list_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      list_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      list_q <= list_d;
    end
  end

  // Next state and commands.
  always_comb begin
    st_d        = st_q;
    list_d      = list_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;

    unique case (st_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load_d = 1'b1;
          list_d       = 1'b0;
          unique case (req_type_i)
            REQ_INSERT: begin
              if (sts_i.occ_full) begin
                cmd_o.res_op = RES_FULL;
                st_d         = ST_CNT_START;
              end else if (sts_i.occ_zero) begin
                cmd_o.idx_op = IDX_ZERO;
                st_d         = ST_INS_PUT;
              end else begin
                cmd_o.idx_op = IDX_OCC;
                st_d         = ST_INS_RD;
              end
            end
            REQ_FIND: begin
              if (sts_i.occ_zero) begin
                cmd_o.res_op  = RES_EMPTY;
                cmd_o.cnt_clr = 1'b1;
                st_d          = ST_EMIT;
              end else begin
                cmd_o.idx_op = IDX_ZERO;
                st_d         = ST_FND_RD;
              end
            end
            REQ_COUNT: begin
              cmd_o.res_op = RES_ZERO;
              st_d         = ST_CNT_START;
            end
            REQ_LIST: begin
              list_d = 1'b1;
              st_d   = ST_CNT_START;
            end
            REQ_CLEAR: begin
              cmd_o.occ_clr = 1'b1;
              cmd_o.cnt_clr = 1'b1;
              cmd_o.res_op  = RES_ZERO;
              st_d          = ST_EMIT;
            end
            default: begin
              cmd_o.res_op = RES_ZERO;
              st_d         = ST_CNT_START;
            end
          endcase
        end
      end

      // Insert: walk down from the top, moving up every entry not below d.
      ST_INS_RD: begin
        cmd_o.rd_prev = 1'b1;
        st_d          = ST_INS_EV;
      end
      ST_INS_EV: begin
        if (sts_i.ge) begin
          cmd_o.mem_we = 1'b1;
          cmd_o.idx_op = IDX_DEC;
          st_d         = sts_i.idx_one ? ST_INS_PUT : ST_INS_RD;
        end else begin
          st_d = ST_INS_PUT;
        end
      end
      ST_INS_PUT: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.wr_d    = 1'b1;
        cmd_o.occ_inc = 1'b1;
        cmd_o.res_op  = RES_INS;
        st_d          = ST_CNT_START;
      end

      // Find: walk up to the first entry not below d, keeping its neighbor.
      ST_FND_RD: begin
        st_d = ST_FND_EV;
      end
      ST_FND_EV: begin
        if (sts_i.ge || sts_i.idx_last) begin
          cmd_o.res_op = RES_FIND;
          st_d         = ST_CNT_START;
        end else begin
          cmd_o.prev_load = 1'b1;
          cmd_o.idx_op    = IDX_INC;
          st_d            = ST_FND_RD;
        end
      end

      // Unique count: one pass over the occupied entries.
      ST_CNT_START: begin
        cmd_o.cnt_clr = 1'b1;
        cmd_o.idx_op  = IDX_ZERO;
        if (sts_i.occ_zero) begin
          st_d = list_q ? ST_LST_START : ST_EMIT;
        end else begin
          st_d = ST_CNT_RD;
        end
      end
      ST_CNT_RD: begin
        st_d = ST_CNT_EV;
      end
      ST_CNT_EV: begin
        cmd_o.cnt_step  = 1'b1;
        cmd_o.prev_load = 1'b1;
        if (sts_i.idx_last) begin
          st_d = list_q ? ST_LST_START : ST_EMIT;
        end else begin
          cmd_o.idx_op = IDX_INC;
          st_d         = ST_CNT_RD;
        end
      end

      // Single result of the request.
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_op = OUT_RES;
          st_d         = ST_IDLE;
        end
      end

      // Listing: each listed entry is held back until the next one is found,
      // so the final one can carry the last mark.
      ST_LST_START: begin
        cmd_o.idx_op  = IDX_ZERO;
        cmd_o.lst_clr = 1'b1;
        st_d          = sts_i.occ_zero ? ST_LST_FIN : ST_LST_RD;
      end
      ST_LST_RD: begin
        st_d = ST_LST_EV;
      end
      ST_LST_EV: begin
        if (sts_i.listed) begin
          if (!sts_i.pend_valid || sts_i.out_free) begin
            cmd_o.lst_take = 1'b1;
            if (sts_i.pend_valid) begin
              cmd_o.out_op = OUT_PEND_MID;
            end
            if (sts_i.k_last || sts_i.idx_last) begin
              st_d = ST_LST_FIN;
            end else begin
              cmd_o.idx_op = IDX_INC;
              st_d         = ST_LST_RD;
            end
          end
        end else if (sts_i.idx_last) begin
          st_d = ST_LST_FIN;
        end else begin
          cmd_o.idx_op = IDX_INC;
          st_d         = ST_LST_RD;
        end
      end
      ST_LST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_op = sts_i.pend_valid ? OUT_PEND_LAST : OUT_MARK;
          st_d         = ST_IDLE;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sorted_distance_table.sv =====
// ----------------------------------------------------------------------------
// sorted_distance_table: ascending distance table with nearest-value search
// Per request, clear and an empty find go straight to the result; count,
// unused codes and a full insert make a count pass; a find walks up, then
// counts; an insert walks down moving entries, writes, then counts; a list
// counts, then makes a listing pass. Reset: empty table, resolution 10. One
// request at a time; idle returns as the last result is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_distance_table import sdt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sdt_req_if.sink   req_i,
  sdt_rsp_if.source rsp_o,
  sdt_cfg_if.sink   cfg_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The resolution register takes a write in any cycle.
  assign cfg_i.ready = 1'b1;

  // Sequencer.
  sdt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Table, compares and result register.
  sdt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .distance_i     (req_i.distance),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_data_i     (cfg_i.data),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_o.valid),
    .status_o       (rsp_o.status),
    .value_o        (rsp_o.value),
    .position_o     (rsp_o.position),
    .unique_count_o (rsp_o.unique_count),
    .last_o         (rsp_o.last)
  );

endmodule

// ===== rtl/sdt_checker.sv =====
// ----------------------------------------------------------------------------
// sdt_checker: port-level checks of the sorted distance table
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdt_checker import sdt_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [STAT_W-1:0]  status_i,
  input logic [VALUE_W-1:0] value_i,
  input logic [POS_W-1:0]   position_i,
  input logic               last_i
);

  // A stalled result transaction keeps its payload.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) &&
      $stable(value_i) && $stable(position_i) && $stable(last_i))
    else $error("result changed while stalled");

  // Requests are worked one at a time.
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in work");

  // A dropped insert reports position zero and closes its request.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == STAT_FULL) |-> (position_i == '0) && last_i)
    else $error("full status with bad fields");

  // An empty-table result carries no entry and closes its request.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == STAT_EMPTY) |->
      (value_i == '0) && (position_i == '0) && last_i)
    else $error("empty status with bad fields");

endmodule

bind sorted_distance_table sdt_checker u_sdt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .status_i    (rsp_o.status),
  .value_i     (rsp_o.value),
  .position_i  (rsp_o.position),
  .last_i      (rsp_o.last)
);

// ===== tb/tb_sorted_distance_table.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_distance_table: self-checking testbench of the sorted distance table
// A short table of directed requests covers the empty table, the extreme
// distances, ties, equal entries and the unused request codes. Three random
// phases follow, each at its own resolution and idling mix, one of them
// filling the table past its depth. Every result is checked against a typed
// expectation or a behavioral model of the table kept inside the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_distance_table;
  import sdt_pkg::*;

  localparam int TBL_DEPTH = 64;

  // Unused request codes; the block answers them without touching the table.
  localparam logic [REQ_W-1:0] REQ_RSVD5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

  // Cycles to let the block settle after its last result (longest list walk).
  localparam int SETTLE_CYCLES = 4 * TBL_DEPTH + 8;
  localparam int LONG_HOLD     = 300;

  typedef struct packed {
    stat_e              status;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
    logic [UC_W-1:0]    unique_count;
    logic               last;
  } result_t;

  typedef struct {
    logic [REQ_W-1:0]   kind;
    logic [VALUE_W-1:0] operand;
    bit                 typed;
    result_t            want;
  } stim_row_t;

  localparam result_t NO_CHECK = '0;

  logic clk_i;
  logic rst_ni;

  sdt_req_if req_ch ();
  sdt_rsp_if rsp_ch ();
  sdt_cfg_if cfg_ch ();

  sorted_distance_table #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch),
    .cfg_i (cfg_ch)
  );

  // Model state of the table and its resolution register.
  logic [VALUE_W-1:0] dist_table [TBL_DEPTH];
  int unsigned        table_fill   = 0;
  logic [VALUE_W-1:0] resolution_q = RES_RESET;
  int                 full_rejects = 0;

  result_t pending_results [$];
  int      mismatches   = 0;
  int      src_idle_pct = 8;
  int      snk_idle_pct = 67;
  bit      hold_go      = 1'b0;
  bit      rsp_hold     = 1'b0;

  // Directed requests. Rows with a typed result are checked against it;
  // the others are checked against the table model.
  stim_row_t directed_rows [24] = '{
    '{REQ_FIND,   32'h1234_5678, 1'b1, '{STAT_EMPTY, 32'h0, 6'd0, 7'd0, 1'b1}},
    '{REQ_COUNT,  32'h0000_0000, 1'b1, '{STAT_OK, 32'h0, 6'd0, 7'd0, 1'b1}},
    '{REQ_LIST,   32'h0000_0000, 1'b1, '{STAT_EMPTY, 32'h0, 6'd0, 7'd0, 1'b1}},
    '{REQ_RSVD5,  32'h0000_0000, 1'b1, '{STAT_OK, 32'h0, 6'd0, 7'd0, 1'b1}},
    '{REQ_INSERT, 32'h0000_0000, 1'b1, '{STAT_OK, 32'h0, 6'd0, 7'd1, 1'b1}},
    '{REQ_INSERT, 32'hFFFF_FFFF, 1'b1, '{STAT_OK, 32'hFFFF_FFFF, 6'd1, 7'd2, 1'b1}},
    '{REQ_INSERT, 32'h0010_0000, 1'b0, NO_CHECK},
    '{REQ_INSERT, 32'h0010_0000, 1'b0, NO_CHECK},
    '{REQ_INSERT, 32'h0010_000A, 1'b0, NO_CHECK},
    '{REQ_INSERT, 32'h0010_000B, 1'b0, NO_CHECK},
    '{REQ_FIND,   32'h0000_0000, 1'b0, NO_CHECK},
    '{REQ_FIND,   32'hFFFF_FFFF, 1'b0, NO_CHECK},
    '{REQ_FIND,   32'h0008_0000, 1'b0, NO_CHECK},
    '{REQ_FIND,   32'h8000_0000, 1'b0, NO_CHECK},
    '{REQ_COUNT,  32'h0000_0000, 1'b0, NO_CHECK},
    '{REQ_LIST,   32'h0000_0000, 1'b0, NO_CHECK},
    '{REQ_RSVD6,  32'hFFFF_FFFF, 1'b0, NO_CHECK},
    '{REQ_RSVD7,  32'h0000_0000, 1'b0, NO_CHECK},
    '{REQ_CLEAR,  32'h0000_0000, 1'b1, '{STAT_OK, 32'h0, 6'd0, 7'd0, 1'b1}},
    '{REQ_LIST,   32'h0000_0000, 1'b1, '{STAT_EMPTY, 32'h0, 6'd0, 7'd0, 1'b1}},
    '{REQ_INSERT, 32'h5A5A_5A5A, 1'b0, NO_CHECK},
    '{REQ_INSERT, 32'hA5A5_A5A5, 1'b0, NO_CHECK},
    '{REQ_LIST,   32'h0000_0000, 1'b0, NO_CHECK},
    '{REQ_FIND,   32'h7FFF_FFFF, 1'b0, NO_CHECK}
  };

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Number of distinct distances at the current resolution.
  function automatic logic [UC_W-1:0] model_unique_total();
    int unsigned n;
    if (table_fill == 0) return '0;
    n = 1;
    for (int unsigned i = 1; i < table_fill; i++) begin
      if (dist_table[i] - dist_table[i-1] > resolution_q) n++;
    end
    return UC_W'(n);
  endfunction

  // Index of the first entry that is not less than the distance.
  function automatic int unsigned model_first_not_less(logic [VALUE_W-1:0] d);
    int unsigned i;
    i = 0;
    while (i < table_fill && dist_table[i] < d) i++;
    return i;
  endfunction

  // Apply one request to the table model and collect its results.
  function automatic void predict_table_request(input logic [REQ_W-1:0] kind,
                                                input logic [VALUE_W-1:0] d,
                                                ref result_t res [$]);
    int unsigned     p;
    logic [UC_W-1:0] cap;
    longint          prev;
    longint          cur;
    longint          res_wide;
    res.delete();
    case (kind)
      REQ_INSERT: begin
        if (table_fill >= TBL_DEPTH) begin
          res.insert(res.size(), '{STAT_FULL, d, 6'd0, model_unique_total(), 1'b1});
          full_rejects++;
        end else begin
          p = model_first_not_less(d);
          for (int unsigned i = table_fill; i > p; i--) dist_table[i] = dist_table[i-1];
          dist_table[p] = d;
          table_fill++;
          res.insert(res.size(), '{STAT_OK, d, POS_W'(p), model_unique_total(), 1'b1});
        end
      end
      REQ_FIND: begin
        if (table_fill == 0) begin
          res.insert(res.size(), '{STAT_EMPTY, 32'h0, 6'd0, 7'd0, 1'b1});
        end else begin
          p = model_first_not_less(d);
          // On a tie the later entry wins, so only a strictly closer
          // lower neighbor moves the pick down.
          if (p == table_fill) begin
            p--;
          end else if (p != 0 && (d - dist_table[p-1]) < (dist_table[p] - d)) begin
            p--;
          end
          res.insert(res.size(),
                     '{STAT_OK, dist_table[p], POS_W'(p), model_unique_total(), 1'b1});
        end
      end
      REQ_COUNT: res.insert(res.size(), '{STAT_OK, 32'h0, 6'd0, model_unique_total(), 1'b1});
      REQ_LIST: begin
        cap      = model_unique_total();
        res_wide = resolution_q;
        // Listing starts from minus one in the fixed-point scale.
        prev     = -(longint'(1) << FRACTION_BITS);
        for (int unsigned i = 0; i < table_fill && res.size() < cap; i++) begin
          cur = dist_table[i];
          if (cur - prev > res_wide) begin
            res.insert(res.size(), '{STAT_OK, dist_table[i], POS_W'(i), cap, 1'b0});
            prev = cur;
          end
        end
        if (res.size() == 0) begin
          res.insert(res.size(), '{stat_e'((table_fill == 0) ? STAT_EMPTY : STAT_OK),
                                   32'h0, 6'd0, cap, 1'b1});
        end else begin
          res[res.size()-1].last = 1'b1;
        end
      end
      REQ_CLEAR: begin
        table_fill = 0;
        res.insert(res.size(), '{STAT_OK, 32'h0, 6'd0, 7'd0, 1'b1});
      end
      default: res.insert(res.size(), '{STAT_OK, 32'h0, 6'd0, model_unique_total(), 1'b1});
    endcase
  endfunction

  // Offer one request; returns at the falling edge after its transaction.
  task automatic send_request(input logic [REQ_W-1:0] kind,
                              input logic [VALUE_W-1:0] operand,
                              input bit typed, input result_t want);
    result_t predicted [$];
    // The sender keeps offering while the receiver is held off.
    while (!rsp_hold && $urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.distance <= operand;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    predict_table_request(kind, operand, predicted);
    if (typed) begin
      pending_results.insert(pending_results.size(), want);
    end else begin
      foreach (predicted[i]) pending_results.insert(pending_results.size(), predicted[i]);
    end
    @(negedge clk_i);
  endtask

  task automatic stop_requests();
    req_ch.valid <= 1'b0;
  endtask

  // Wait for every expected result, then for the block to go idle.
  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_resolution(input logic [VALUE_W-1:0] res);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= res;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    resolution_q = res;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Distances: extremes, near neighbors of stored entries, small and wide values.
  function automatic logic [VALUE_W-1:0] pick_distance();
    logic [VALUE_W-1:0] base;
    int unsigned        span;
    span = (resolution_q > 32'd1000) ? 32 : 2 * resolution_q + 2;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: begin
        if (table_fill == 0) return $urandom;
        base = dist_table[$urandom_range(0, table_fill - 1)];
        return base + $urandom_range(0, span);
      end
      5, 6: return $urandom_range(0, 32'h0040_0000);
      default: return $urandom;
    endcase
  endfunction

  // Request mix; the fill mix is mostly inserts and never clears.
  function automatic logic [REQ_W-1:0] pick_kind(input bit fill_table);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (fill_table) begin
      if (r < 85) return REQ_INSERT;
      if (r < 92) return REQ_FIND;
      if (r < 95) return REQ_COUNT;
      return REQ_LIST;
    end
    if (r < 40) return REQ_INSERT;
    if (r < 60) return REQ_FIND;
    if (r < 70) return REQ_COUNT;
    if (r < 83) return REQ_LIST;
    if (r < 93) return REQ_CLEAR;
    case ($urandom_range(0, 2))
      0: return REQ_RSVD5;
      1: return REQ_RSVD6;
      default: return REQ_RSVD7;
    endcase
  endfunction

  task automatic run_random_phase(input int n_items, input bit fill_table);
    int               sent;
    logic [REQ_W-1:0] kind;
    sent = 0;
    // A fill phase goes on until several inserts were refused by a full table.
    while (sent < n_items || (fill_table && full_rejects < 3)) begin
      kind = pick_kind(fill_table);
      send_request(kind, pick_distance(), 1'b0, NO_CHECK);
      sent++;
    end
    stop_requests();
  endtask

  // Result receiver: random back-pressure, plus one long hold-off.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_ch.ready <= !(rsp_hold || ($urandom_range(0, 99) < snk_idle_pct));
    end
  end

  // Long hold-off of the receiver so that the block stalls its input.
  initial begin
    wait (hold_go);
    rsp_hold = 1'b1;
    repeat (LONG_HOLD) @(negedge clk_i);
    rsp_hold = 1'b0;
  end

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with nothing expected: status %0d value %0h position %0d",
                 $time, rsp_ch.status, rsp_ch.value, rsp_ch.position);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, rsp_ch.status);
        check_field("value", want.value, rsp_ch.value);
        check_field("position", want.position, rsp_ch.position);
        check_field("unique_count", want.unique_count, rsp_ch.unique_count);
        check_field("last", want.last, rsp_ch.last);
      end
    end
  end

  // Main sequence.
  initial begin
    rst_ni          = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = '0;
    req_ch.distance = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset resolution.
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].kind, directed_rows[i].operand,
                   directed_rows[i].typed, directed_rows[i].want);
    end
    stop_requests();

    // Phase one: zero resolution, slow receiver.
    write_resolution('0);
    run_random_phase(20, 1'b0);

    // Phase two: moderate resolution, slow sender, table filled past its depth.
    write_resolution($urandom_range(16, 600));
    src_idle_pct = 67;
    snk_idle_pct = 8;
    full_rejects = 0;
    hold_go      = 1'b1;
    run_random_phase(60, 1'b1);

    // Phase three: largest resolution, no idling on either side.
    write_resolution('1);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random_phase(20, 1'b0);

    wait_drained();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sdt_pkg.sv
rtl/sdt_ifs.sv
rtl/sdt_dp.sv
rtl/sdt_ctrl.sv
rtl/sorted_distance_table.sv
rtl/sdt_checker.sv
tb/tb_sorted_distance_table.sv
